### rtl/pjpt_pkg.sv
// Shared types and constants of the pending jump patch table.
package pjpt_pkg;

	typedef enum logic [1:0] {
		KIND_RECORDED = 2'd0,
		KIND_DROPPED  = 2'd1,
		KIND_PATCH    = 2'd2,
		KIND_NO_MATCH = 2'd3
	} kind_t;

	localparam logic ACT_RECORD  = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	localparam logic [5:0]  J_OPCODE      = 6'd2;
	localparam logic [31:0] J_TARGET_MASK = 32'h03FF_FFFF;

endpackage

### rtl/pjpt_if.sv
// Valid/ready channel interfaces for request and result items.
interface pjpt_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] guest_target;
	logic [31:0] host_address;

	modport source (output valid, action, guest_target, host_address, input ready);
	modport sink   (input valid, action, guest_target, host_address, output ready);
endinterface

interface pjpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] site_address;
	logic [31:0] patch_word;
	logic        last;

	modport source (output valid, kind, site_address, patch_word, last, input ready);
	modport sink   (input valid, kind, site_address, patch_word, last, output ready);
endinterface

### rtl/pending_jump_patch_table_unit.sv
// Pending jump patch table: ordered site table with record and resolve.
// Record: its result is registered, valid the cycle after the request is accepted.
// Resolve: one stored entry read, matched and compacted per cycle through the
// registered table memory, slower while results stall.
// One item at a time: no new request is taken until a resolve is through.
// Reset: entry count and prologue_q clear; table contents stay undefined.
module pending_jump_patch_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	pjpt_req_if.sink    req,
	pjpt_rsp_if.source  rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	state_t              state_q;
	logic [7:0]          prologue_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    kept_q;
	logic                rd_vld_s1;
	logic [63:0]         rd_data_s1;
	logic [31:0]         tgt_q;
	logic [31:0]         word_q;
	logic                pend_q;
	logic [31:0]         pend_site_q;

	logic                out_vld_q;
	pjpt_pkg::kind_t     out_kind_q;
	logic [31:0]         out_site_q;
	logic [31:0]         out_word_q;
	logic                out_last_q;

	logic [63:0]         mem [TABLE_DEPTH];

	logic                slot_free;
	logic                accept;
	logic                hit;
	logic                adv;
	logic                rd_en;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [63:0]         wr_data;
	logic                emit;
	pjpt_pkg::kind_t     emit_kind;
	logic [31:0]         emit_site;
	logic [31:0]         emit_word;
	logic                emit_last;
	logic [31:0]         jump_sum;

	assign slot_free = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign hit       = rd_data_s1[63:32] == tgt_q;
	assign adv       = !(rd_vld_s1 && hit && pend_q) || slot_free;
	assign rd_en     = (state_q == ST_SCAN) && adv && (rd_idx_q < count_q);
	assign jump_sum  = req.host_address + {22'd0, prologue_q, 2'b00};

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = kept_q[IDX_W-1:0];
		wr_data   = rd_data_s1;
		emit      = 1'b0;
		emit_kind = pjpt_pkg::KIND_RECORDED;
		emit_site = '0;
		emit_word = '0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.action == pjpt_pkg::ACT_RECORD) begin
					emit = 1'b1;
					if (count_q < DEPTH_C) begin
						wr_en     = 1'b1;
						wr_addr   = count_q[IDX_W-1:0];
						wr_data   = {req.guest_target, req.host_address};
						emit_kind = pjpt_pkg::KIND_RECORDED;
					end else begin
						emit_kind = pjpt_pkg::KIND_DROPPED;
					end
				end
			end
			ST_SCAN: begin
				if (rd_vld_s1 && adv) begin
					if (hit) begin
						if (pend_q) begin
							emit      = 1'b1;
							emit_kind = pjpt_pkg::KIND_PATCH;
							emit_site = pend_site_q;
							emit_word = word_q;
							emit_last = 1'b0;
						end
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					emit = 1'b1;
					if (pend_q) begin
						emit_kind = pjpt_pkg::KIND_PATCH;
						emit_site = pend_site_q;
						emit_word = word_q;
					end else begin
						emit_kind = pjpt_pkg::KIND_NO_MATCH;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prologue_q  <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			kept_q      <= '0;
			rd_vld_s1   <= 1'b0;
			pend_q      <= 1'b0;
			out_vld_q   <= 1'b0;
			tgt_q       <= '0;
			word_q      <= '0;
			pend_site_q <= '0;
			out_kind_q  <= pjpt_pkg::KIND_RECORDED;
			out_site_q  <= '0;
			out_word_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				prologue_q <= cfg_wdata;
			end

			if (emit) begin
				out_vld_q  <= 1'b1;
				out_kind_q <= emit_kind;
				out_site_q <= emit_site;
				out_word_q <= emit_word;
				out_last_q <= emit_last;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.action == pjpt_pkg::ACT_RECORD) begin
							if (count_q < DEPTH_C) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							tgt_q    <= req.guest_target;
							word_q   <= {pjpt_pkg::J_OPCODE, 26'd0} |
								({2'b00, jump_sum[31:2]} & pjpt_pkg::J_TARGET_MASK);
							rd_idx_q <= '0;
							kept_q   <= '0;
							pend_q   <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && adv) begin
						if (hit) begin
							pend_q      <= 1'b1;
							pend_site_q <= rd_data_s1[31:0];
						end else begin
							kept_q <= kept_q + CNT_W'(1);
						end
					end
					if (adv) begin
						rd_vld_s1 <= rd_en;
						if (rd_en) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
					if (!rd_vld_s1 && rd_idx_q >= count_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						count_q <= kept_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.site_address = out_site_q;
	assign rsp.patch_word   = out_word_q;
	assign rsp.last         = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count exceeds table depth");

	a_kept_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (kept_q <= rd_idx_q))
		else $error("compaction write index passed read index");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("table read data pending outside scan");

	a_finish_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && slot_free) |=> (count_q == $past(kept_q)))
		else $error("entry count not updated after resolve");

endmodule
